// ===== rtl/wildcard_byte_signature_scan_core_macros.svh =====
// ----------------------------------------------------------------------------
// wildcard byte signature scan assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_CORE_MACROS_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_CORE_MACROS_SVH

`ifndef SYNTHESIS
// plain property, may carry its own implication
`define WBSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wbss assertion failed");
// antecedent in this cycle, consequent in the next
`define WBSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wbss assertion failed");
`else
`define WBSS_ASSERT(lbl, prop)
`define WBSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/wbss_pkg.sv =====
// ----------------------------------------------------------------------------
// wbss_pkg
// shared constants, beat types and register indexes of the signature scanner
// ----------------------------------------------------------------------------
`default_nettype none

package wbss_pkg;

  localparam int MAX_SIGNATURE_BYTES = 16;
  localparam int ADDRESS_BITS        = 48;

  // bytes held by the two pattern registers
  localparam int PAT_BYTES  = 16;
  localparam int PAT_IDX_W  = $clog2(PAT_BYTES);
  localparam int SIG_LIMIT  = (MAX_SIGNATURE_BYTES < PAT_BYTES) ? MAX_SIGNATURE_BYTES
                                                                  : PAT_BYTES;
  localparam int LEN_W      = 5;
  localparam int FILL_W     = $clog2(MAX_SIGNATURE_BYTES + 1);
  localparam int CELL_IDX_W = $clog2(MAX_SIGNATURE_BYTES);
  localparam int CNT_W0     = (FILL_W > LEN_W) ? FILL_W : LEN_W;
  localparam int CNT_W      = (CNT_W0 > CELL_IDX_W) ? CNT_W0 : CELL_IDX_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_WILDCARD     = 3'd2,
    CFG_LENGTH       = 3'd3,
    CFG_BASE_ADDR    = 3'd4
  } cfg_idx_e;

  typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       range_start;
    logic       range_end;
  } in_beat_t;

  typedef struct packed {
    logic                    hit_now;
    logic [ADDRESS_BITS-1:0] hit_address;
    logic [ADDRESS_BITS-1:0] first_hit_address;
    logic                    found_any;
    logic                    multiple_matches;
    logic                    scan_done;
  } out_beat_t;

  // per-cell compare result
  typedef struct packed {
    logic mismatch;
    logic care;
  } cell_res_t;

  // compare stage to tally stage
  typedef struct packed {
    logic                    valid;
    logic                    hit;
    logic [ADDRESS_BITS-1:0] hit_address;
    logic                    start;
    logic                    done;
  } cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/wbss_cell.sv =====
// ----------------------------------------------------------------------------
// wbss_cell
// one window byte: shifts toward older positions and compares itself against
// the signature byte that lines up with its age
// ----------------------------------------------------------------------------
`default_nettype none

module wbss_cell
  import wbss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  shift_i,
  input  logic [7:0]            byte_i,
  input  logic [CELL_IDX_W-1:0] cell_idx_i,
  input  logic [LEN_W-1:0]      len_i,
  input  pat_bytes_t            pattern_i,
  input  logic [PAT_BYTES-1:0]  wild_i,
  output logic [7:0]            byte_o,
  output cell_res_t             res_o
);

  logic [7:0]           byte_q;
  logic                 in_use;
  logic [CNT_W-1:0]     diff;
  logic [PAT_IDX_W-1:0] pidx;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // cell of age k lines up with signature byte len-1-k
  always_comb begin
    in_use = CNT_W'(cell_idx_i) < CNT_W'(len_i);
    diff   = CNT_W'(len_i) - CNT_W'(1) - CNT_W'(cell_idx_i);
    pidx   = diff[PAT_IDX_W-1:0];
    res_o.care     = in_use && !wild_i[pidx];
    res_o.mismatch = res_o.care && (byte_q != pattern_i[pidx]);
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ===== rtl/wbss_tally.sv =====
// ----------------------------------------------------------------------------
// wbss_tally
// per-range match bookkeeping and the output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_byte_signature_scan_core_macros.svh"

module wbss_tally
  import wbss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmp_res_t  cmp_i,
  output logic      take_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  localparam logic [1:0] TALLY_SAT = 2'd2;

  logic [1:0]              tally_q, tally_d, tally_base;
  logic [ADDRESS_BITS-1:0] first_q, first_d, first_base;
  logic                    out_valid_q, out_valid_d;
  out_beat_t               out_q, out_d;
  logic                    fire;

  assign take_o = !out_valid_q || out_ready_i;
  assign fire   = cmp_i.valid && take_o;

  always_comb begin
    tally_base = cmp_i.start ? '0 : tally_q;
    first_base = cmp_i.start ? '0 : first_q;
    tally_d    = tally_q;
    first_d    = first_q;
    out_d      = out_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      tally_d = tally_base;
      first_d = first_base;
      if (cmp_i.hit) begin
        if (tally_base == '0) begin
          first_d = cmp_i.hit_address;
        end
        if (tally_base != TALLY_SAT) begin
          tally_d = tally_base + 2'd1;
        end
      end
      out_d.hit_now           = cmp_i.hit;
      out_d.hit_address       = cmp_i.hit_address;
      out_d.first_hit_address = first_d;
      out_d.found_any         = tally_d != '0;
      out_d.multiple_matches  = tally_d == TALLY_SAT;
      out_d.scan_done         = cmp_i.done;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q     <= '0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tally_q     <= tally_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `WBSS_ASSERT_NEXT(a_first_hit_taken, fire && cmp_i.hit && (cmp_i.start || tally_q == '0), out_q.first_hit_address == $past(cmp_i.hit_address))
  `WBSS_ASSERT(a_hit_sets_found, out_valid_q && out_q.hit_now |-> out_q.found_any)
  `WBSS_ASSERT(a_multi_needs_found, out_valid_q && out_q.multiple_matches |-> out_q.found_any)
  `WBSS_ASSERT(a_first_zero_until_found, out_valid_q && !out_q.found_any |-> out_q.first_hit_address == '0)

endmodule

`default_nettype wire

// ===== rtl/wildcard_byte_signature_scan_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_core
// streams memory bytes through a row of window cells and reports every window
// that matches a wildcard signature, with per-range match bookkeeping
// ----------------------------------------------------------------------------
//  port group   dir  handshake             payload
//  in           in   in_valid_i/in_ready_o  in_beat_i  (in_beat_t)
//  out          out  out_valid_o/out_ready_i out_beat_o (out_beat_t)
//  cfg          in   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
//  one byte per cycle sustained while the output is not stalled; each beat passes
//  the window shift, then compare and tally into the output register
//  the row of window cells feeds a single compare stage
//  reset clears control state, fill count, offset, tally and config registers;
//  pattern_length is 1; window cells are not reset, the fill count masks them
//  a stalled output holds its beat while one more input beat can still enter
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_signature_scan_core
  import wbss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_beat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [63:0]             pat_low_q, pat_high_q;
  logic [PAT_BYTES-1:0]    wild_q;
  logic [LEN_W-1:0]        len_q;
  logic [ADDRESS_BITS-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      wild_q     <= '0;
      len_q      <= LEN_W'(1);
      base_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_LOW:  pat_low_q  <= cfg_wdata_i;
        CFG_PATTERN_HIGH: pat_high_q <= cfg_wdata_i;
        CFG_WILDCARD:     wild_q     <= cfg_wdata_i[PAT_BYTES-1:0];
        CFG_LENGTH:       len_q      <= cfg_wdata_i[LEN_W-1:0];
        CFG_BASE_ADDR:    base_q     <= cfg_wdata_i[ADDRESS_BITS-1:0];
        default: ;
      endcase
    end
  end

  pat_bytes_t       pattern;
  logic [LEN_W-1:0] len_eff;

  assign pattern = {pat_high_q, pat_low_q};

  always_comb begin
    len_eff = len_q;
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (CNT_W'(len_q) > CNT_W'(SIG_LIMIT)) begin
      len_eff = LEN_W'(SIG_LIMIT);
    end
  end

  // shift stage: window cells, fill count and byte address
  logic                    take_b;
  logic                    accept;
  logic                    a_valid_q;
  logic                    a_start_q, a_end_q;
  logic [ADDRESS_BITS-1:0] a_addr_q;
  logic [ADDRESS_BITS-1:0] offset_q, cur_off;
  logic [FILL_W-1:0]       fill_q, fill_d;

  assign in_ready_o = !a_valid_q || take_b;
  assign accept     = in_valid_i && in_ready_o;
  assign cur_off    = in_beat_i.range_start ? '0 : offset_q;

  always_comb begin
    fill_d = fill_q;
    if (in_beat_i.range_start) begin
      fill_d = FILL_W'(1);
    end else if (CNT_W'(fill_q) < CNT_W'(MAX_SIGNATURE_BYTES)) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      offset_q  <= '0;
      fill_q    <= '0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
        offset_q  <= cur_off + ADDRESS_BITS'(1);
        fill_q    <= fill_d;
      end else if (take_b) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_start_q <= in_beat_i.range_start;
      a_end_q   <= in_beat_i.range_end;
      a_addr_q  <= base_q + cur_off;
    end
  end

  // row of window cells, cell 0 holds the newest byte
  logic [MAX_SIGNATURE_BYTES:0][7:0]  chain;
  logic [MAX_SIGNATURE_BYTES-1:0]     mism_vec, care_vec;

  assign chain[0] = in_beat_i.data_byte;

  for (genvar k = 0; k < MAX_SIGNATURE_BYTES; k++) begin : g_cell
    cell_res_t res;

    wbss_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (accept),
      .byte_i     (chain[k]),
      .cell_idx_i (CELL_IDX_W'(k)),
      .len_i      (len_eff),
      .pattern_i  (pattern),
      .wild_i     (wild_q),
      .byte_o     (chain[k+1]),
      .res_o      (res)
    );

    assign mism_vec[k] = res.mismatch;
    assign care_vec[k] = res.care;
  end

  // compare result; a signature of wildcards only has no cared byte
  cmp_res_t cmp;
  logic     hit;

  assign hit = (CNT_W'(fill_q) >= CNT_W'(len_eff)) && !(|mism_vec) && (|care_vec);

  always_comb begin
    cmp.valid       = a_valid_q;
    cmp.hit         = hit;
    cmp.hit_address = hit ? a_addr_q - ADDRESS_BITS'(len_eff - LEN_W'(1)) : '0;
    cmp.start       = a_start_q;
    cmp.done        = a_end_q;
  end

  wbss_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmp_i       (cmp),
    .take_o      (take_b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== tb/wbss_match_checker.sv =====
// ----------------------------------------------------------------------------
// wbss_match_checker
// watches the config port and both beat channels of the signature scanner,
// keeps its own copy of the registers and the scan window, predicts the
// result beat for every accepted byte and compares the result beats in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wbss_match_checker
  import wbss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_beat_t              in_beat_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_beat_t             out_beat_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatch_total_o,
  output int                    results_owed_o
);

  // register copies
  logic [63:0]             sig_low;
  logic [63:0]             sig_high;
  logic [15:0]             wild_bits;
  logic [4:0]              sig_len;
  logic [ADDRESS_BITS-1:0] range_base;

  // scan state, entry 0 holds the newest byte
  logic [7:0]              scan_window [MAX_SIGNATURE_BYTES];
  int                      window_fill;
  logic [ADDRESS_BITS-1:0] byte_offset;
  logic [ADDRESS_BITS-1:0] first_hit;
  int                      hit_tally;

  out_beat_t               expected_results [$];

  task automatic clear_scan();
    for (int i = 0; i < MAX_SIGNATURE_BYTES; i++) scan_window[i] = '0;
    window_fill = 0;
    byte_offset = '0;
    first_hit   = '0;
    hit_tally   = 0;
  endtask

  task automatic scan_next_byte(input in_beat_t beat, output out_beat_t res);
    pat_bytes_t              sig;
    int                      span;
    logic                    hit;
    logic                    all_wild;
    logic [ADDRESS_BITS-1:0] cur_addr;
    logic [ADDRESS_BITS-1:0] back;
    logic [ADDRESS_BITS-1:0] hit_addr;
    if (beat.range_start) clear_scan();
    for (int i = MAX_SIGNATURE_BYTES - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
    scan_window[0] = beat.data_byte;
    if (window_fill < MAX_SIGNATURE_BYTES) window_fill++;

    span = int'(sig_len);
    if (span == 0) span = 1;
    if (span > SIG_LIMIT) span = SIG_LIMIT;

    sig      = {sig_high, sig_low};
    cur_addr = range_base + byte_offset;
    hit      = 1'b0;
    all_wild = 1'b1;
    if (window_fill >= span) begin
      hit = 1'b1;
      for (int i = 0; i < span; i++) begin
        if (!wild_bits[i]) begin
          all_wild = 1'b0;
          // signature byte 0 lines up with the oldest byte of the window
          if (scan_window[span-1-i] != sig[i]) hit = 1'b0;
        end
      end
      if (all_wild) hit = 1'b0;
    end

    hit_addr = '0;
    if (hit) begin
      back     = ADDRESS_BITS'(span - 1);
      hit_addr = cur_addr - back;
      if (hit_tally == 0) first_hit = hit_addr;
      if (hit_tally < 2) hit_tally++;
    end
    byte_offset = byte_offset + ADDRESS_BITS'(1);

    res.hit_now           = hit;
    res.hit_address       = hit_addr;
    res.first_hit_address = first_hit;
    res.found_any         = (hit_tally >= 1);
    res.multiple_matches  = (hit_tally >= 2);
    res.scan_done         = beat.range_end;
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_total_o++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    out_beat_t want;
    if (!rst_ni) begin
      sig_low          = '0;
      sig_high         = '0;
      wild_bits        = '0;
      sig_len          = 5'd1;
      range_base       = '0;
      clear_scan();
      expected_results.delete();
      mismatch_total_o = 0;
      results_owed_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN_LOW:  sig_low    = cfg_wdata_i;
          CFG_PATTERN_HIGH: sig_high   = cfg_wdata_i;
          CFG_WILDCARD:     wild_bits  = cfg_wdata_i[15:0];
          CFG_LENGTH:       sig_len    = cfg_wdata_i[4:0];
          CFG_BASE_ADDR:    range_base = cfg_wdata_i[ADDRESS_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat expected none actual %0h", $time, out_beat_i);
          mismatch_total_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit_now", want.hit_now, out_beat_i.hit_now);
          check_field("hit_address", want.hit_address, out_beat_i.hit_address);
          check_field("first_hit_address", want.first_hit_address,
                      out_beat_i.first_hit_address);
          check_field("found_any", want.found_any, out_beat_i.found_any);
          check_field("multiple_matches", want.multiple_matches,
                      out_beat_i.multiple_matches);
          check_field("scan_done", want.scan_done, out_beat_i.scan_done);
        end
      end
      if (in_valid_i && in_ready_i) begin
        scan_next_byte(in_beat_i, want);
        expected_results.push_back(want);
      end
      results_owed_o = expected_results.size();
    end
  end

endmodule

// ===== tb/tb_wildcard_byte_signature_scan_core.sv =====
// ----------------------------------------------------------------------------
// tb_wildcard_byte_signature_scan_core
// drives byte ranges into the signature scanner under random idles and
// back-pressure, reprograms the signature between phases and leaves the
// checking to wbss_match_checker; in the random phases, signature replays,
// some with one byte spoiled, alternate with runs of noise
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_wildcard_byte_signature_scan_core;
  import wbss_pkg::*;

  localparam int IDLE_MAX     = 6;
  localparam int PHASE_BYTES  = 100;
  localparam int PHASE_COUNT  = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_beat_t              in_beat   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_beat_t             out_beat;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_total;
  int results_owed;
  int quiet_cycles = 0;
  int bytes_sent   = 0;
  bit smooth_flow  = 1'b0;

  // signature as last programmed, used to build matching runs
  pat_bytes_t  sig_now  = '0;
  logic [15:0] wild_now = '0;
  int          span_now = 1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  wildcard_byte_signature_scan_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  wbss_match_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_beat_i        (in_beat),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_beat_i       (out_beat),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_total_o (mismatch_total),
    .results_owed_o   (results_owed)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("wildcard_byte_signature_scan_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin : result_drain
    int stall;
    @(negedge clk);
    forever begin
      stall = smooth_flow ? 0 : int'($urandom_range(0, IDLE_MAX));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
    int       gap;
    in_beat_t beat;
    gap = smooth_flow ? 0 : int'($urandom_range(0, IDLE_MAX));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    beat.data_byte   = data;
    beat.range_start = first;
    beat.range_end   = last;
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic scan_byte(input logic [7:0] data);
    send_byte(data, $urandom_range(0, 39) == 0, $urandom_range(0, 11) == 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic apply_setup(input logic [63:0] low, input logic [63:0] high,
                             input logic [15:0] mask, input logic [4:0] len,
                             input logic [ADDRESS_BITS-1:0] base);
    write_reg(CFG_PATTERN_LOW, low);
    write_reg(CFG_PATTERN_HIGH, high);
    write_reg(CFG_WILDCARD, CFG_DATA_W'(mask));
    write_reg(CFG_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_BASE_ADDR, CFG_DATA_W'(base));
    // index past the register list must be ignored
    write_reg(CFG_UNMAPPED, {$urandom, $urandom});
    cfg_we   <= 1'b0;
    sig_now  = {high, low};
    wild_now = mask;
    span_now = (len == 0) ? 1 : (len > SIG_LIMIT) ? SIG_LIMIT : int'(len);
  endtask

  // replay the signature with random bytes under wildcards, sometimes spoiled
  task automatic emit_signature_run();
    int         spoil;
    logic [7:0] b;
    spoil = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, span_now - 1)) : -1;
    for (int i = 0; i < span_now; i++) begin
      b = wild_now[i] ? 8'($urandom_range(0, 255)) : sig_now[i];
      if (i == spoil) b = b ^ (8'h01 << $urandom_range(0, 7));
      scan_byte(b);
    end
  endtask

  initial begin : stimulus
    logic [4:0]              len;
    logic [15:0]             mask;
    logic [ADDRESS_BITS-1:0] base;
    int                      phase_end;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, no range start: zero byte matches at base zero
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    settle();

    // bytes with the top bit set, address wrap across the second window
    apply_setup(64'h0000_0000_7F00_80FF, '1, 16'h0000, 5'd4, 48'hFFFF_FFFF_FFFE);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);
    settle();

    // overlapping windows, bytes after range end keep the range
    apply_setup(64'h0000_0000_0000_AAAA, '0, 16'h0000, 5'd2, '0);
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b1);
    send_byte(8'hAA, 1'b0, 1'b0);
    settle();

    // every used byte a wildcard: never a match
    apply_setup(64'h0000_0000_0000_AAAA, '0, 16'h0003, 5'd2, 48'h0000_0000_1000);
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    settle();

    // length zero acts as one
    apply_setup(64'h0000_0000_0000_005A, '0, 16'h0000, 5'd0, 48'h0000_0000_0040);
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);
    settle();

    // oversized length clamps to sixteen, window still short
    apply_setup('0, 64'h5A00_0000_0000_0000, 16'h7FFF, 5'd31, '1);
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    settle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 6)
        0: len = 5'd1;
        1: len = 5'd2;
        2: len = 5'd16;
        3: len = 5'd0;
        4: len = 5'($urandom_range(17, 31));
        default: len = 5'($urandom_range(3, 15));
      endcase
      case ($urandom_range(0, 4))
        0: mask = '0;
        1: mask = '1;
        default: mask = 16'($urandom & $urandom);
      endcase
      case ($urandom_range(0, 2))
        0: base = '0;
        1: base = '1 - ADDRESS_BITS'($urandom_range(0, 40));
        default: base = ADDRESS_BITS'({$urandom, $urandom});
      endcase
      apply_setup({$urandom, $urandom}, {$urandom, $urandom}, mask, len, base);
      smooth_flow = ($urandom_range(0, 3) == 0);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(0, 3) != 0) emit_signature_run();
        repeat ($urandom_range(0, 4)) begin
          // half the noise reuses signature bytes to build near misses
          if ($urandom_range(0, 1) == 0) scan_byte(8'($urandom_range(0, 255)));
          else scan_byte(sig_now[$urandom_range(0, span_now - 1)]);
        end
      end
      settle();
      smooth_flow = 1'b0;
    end

    if (mismatch_total == 0 && results_owed == 0) begin
      $display("wildcard_byte_signature_scan_core verification clean");
    end else begin
      $display("wildcard_byte_signature_scan_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wbss_pkg.sv
rtl/wbss_cell.sv
rtl/wbss_tally.sv
rtl/wildcard_byte_signature_scan_core.sv
tb/wbss_match_checker.sv
tb/tb_wildcard_byte_signature_scan_core.sv
